// ----- rtl/core/spe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants for the simple path enumerator: the stack
// entry layout, the stack memory request bundle and the sequencer states.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int NODE_W  = 3;
	localparam int NBR_W   = 4;
	localparam int SLOTS   = 8;
	localparam int DEPTH_W = 4;
	localparam int ADDR_W  = 3;
	localparam int PATH_W  = NODE_W * SLOTS;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [SLOTS-1:0]   mask_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	// one level of the depth-first stack
	typedef struct packed {
		node_t             node;
		logic [NBR_W-1:0]  nbr;
	} stk_entry_t;

	// one write port and one read port per cycle
	typedef struct packed {
		logic       we;
		addr_t      waddr;
		stk_entry_t wdata;
		logic       re;
		addr_t      raddr;
	} stk_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SCAN,
		ST_PUSH,
		ST_DUMP_RD,
		ST_DUMP_CAP
	} state_t;

endpackage

// ----- rtl/core/spe_stack_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_stack_mem
// Depth-first stack storage: node and next-neighbour index per level,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spe_stack_mem
	import spe_pkg::*;
(
	input  logic       clk,
	input  stk_req_t   req,
	output stk_entry_t rd_data
);

	stk_entry_t mem_q [SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem_q[req.raddr];
		end
	end

endmodule

// ----- rtl/core/simple_path_enumerator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_path_enumerator
// Lists every simple path between two nodes of a directed graph, one path
// per command, by walking an explicit depth-first stack held in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Load adjacency rows through the cfg channel (index = row, data bit j =
//   edge to node j); cfg_ready is always high, write only while idle.
//   A command transaction is taken when start is high and busy is low.
//   command 0 loads source_node/target_node_in and returns the first path;
//   command 1 returns the following path, or path_found = 0 when exhausted.
//   The result shows for exactly one cycle with done high, in the first
//   cycle with busy low again; a new command may be issued in that same cycle.
// Search steps (from acceptance to done):
//   each neighbour tried takes a stack read (WALK) and a read-modify-write
//   (SCAN); each level popped takes a stack read and the pop; each push has
//   its own state (PUSH); WALK finds the stack empty when the search runs
//   out; the path is read back out of the stack memory with a read and a
//   capture per node (DUMP_RD, DUMP_CAP), then the result is registered. A
//   start with an invalid endpoint, or a next without an active search, answers straight from the idle state.
// Reset clears the adjacency rows and the search state; stack contents are
// not cleared. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module simple_path_enumerator
	import spe_pkg::*;
#(
	parameter int NODES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic [NODE_W-1:0]   source_node,
	input  logic [NODE_W-1:0]   target_node_in,
	output logic                done,
	output logic [PATH_W-1:0]   path_nodes,
	output logic [DEPTH_W-1:0]  path_length,
	output logic                path_found,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ADDR_W-1:0]   cfg_index,
	input  logic [SLOTS-1:0]    cfg_data
);

	localparam logic [NBR_W-1:0] NODES_N = NBR_W'(NODES);

	state_t      state_q, state_d;
	logic [SLOTS-1:0] adj_q [SLOTS];
	depth_t      depth_q, depth_d;
	mask_t       mask_q, mask_d;
	node_t       goal_q, goal_d;
	logic        active_q, active_d;
	node_t       cand_q, cand_d;
	addr_t       dump_k_q, dump_k_d;
	logic [PATH_W-1:0]  path_q, path_d;
	depth_t      len_q, len_d;
	logic        found_q, found_d;
	logic        done_q, done_d;

	stk_req_t    req;
	stk_entry_t  rd_data;
	addr_t       lvl;
	node_t       top;
	logic [NBR_W-1:0] nbr;

	spe_stack_mem u_stack (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign cfg_ready   = 1'b1;
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign path_nodes  = path_q;
	assign path_length = len_q;
	assign path_found  = found_q;

	assign lvl = ADDR_W'(depth_q - depth_t'(1));
	assign top = rd_data.node;
	assign nbr = rd_data.nbr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < SLOTS; r++) begin
				adj_q[r] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			adj_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			mask_q   <= '0;
			goal_q   <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			depth_q  <= depth_d;
			mask_q   <= mask_d;
			goal_q   <= goal_d;
			active_q <= active_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cand_q   <= cand_d;
		dump_k_q <= dump_k_d;
		path_q   <= path_d;
		len_q    <= len_d;
		found_q  <= found_d;
	end

	always_comb begin
		state_d  = state_q;
		depth_d  = depth_q;
		mask_d   = mask_q;
		goal_d   = goal_q;
		active_d = active_q;
		cand_d   = cand_q;
		dump_k_d = dump_k_q;
		path_d   = path_q;
		len_d    = len_q;
		found_d  = found_q;
		done_d   = 1'b0;
		req      = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_START) begin
						goal_d  = target_node_in;
						depth_d = '0;
						mask_d  = '0;
						if ({1'b0, source_node} >= NODES_N ||
						    {1'b0, target_node_in} >= NODES_N) begin
							active_d = 1'b0;
							path_d   = '0;
							len_d    = '0;
							found_d  = 1'b0;
							done_d   = 1'b1;
						end else begin
							// push the source at level zero
							active_d        = 1'b1;
							req.we          = 1'b1;
							req.waddr       = '0;
							req.wdata.node  = source_node;
							req.wdata.nbr   = (source_node == target_node_in) ?
							                  NODES_N : '0;
							mask_d          = mask_t'(1) << source_node;
							depth_d         = depth_t'(1);
							if (source_node == target_node_in) begin
								dump_k_d = '0;
								path_d   = '0;
								state_d  = ST_DUMP_RD;
							end else begin
								state_d = ST_WALK;
							end
						end
					end else if (active_q) begin
						state_d = ST_WALK;
					end else begin
						path_d  = '0;
						len_d   = '0;
						found_d = 1'b0;
						done_d  = 1'b1;
					end
				end
			end
			ST_WALK: begin
				if (depth_q == '0) begin
					active_d = 1'b0;
					path_d   = '0;
					len_d    = '0;
					found_d  = 1'b0;
					done_d   = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					req.re    = 1'b1;
					req.raddr = lvl;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (nbr >= NODES_N) begin
					// neighbours done: pop the level
					mask_d  = mask_q & ~(mask_t'(1) << top);
					depth_d = depth_q - depth_t'(1);
					state_d = ST_WALK;
				end else begin
					req.we         = 1'b1;
					req.waddr      = lvl;
					req.wdata.node = top;
					req.wdata.nbr  = nbr + NBR_W'(1);
					if (adj_q[top][nbr[ADDR_W-1:0]] && !mask_q[nbr[ADDR_W-1:0]]) begin
						cand_d  = nbr[NODE_W-1:0];
						state_d = ST_PUSH;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_PUSH: begin
				req.we         = 1'b1;
				req.waddr      = depth_q[ADDR_W-1:0];
				req.wdata.node = cand_q;
				// never extend past the goal
				req.wdata.nbr  = (cand_q == goal_q) ? NODES_N : '0;
				mask_d         = mask_q | (mask_t'(1) << cand_q);
				depth_d        = depth_q + depth_t'(1);
				if (cand_q == goal_q) begin
					dump_k_d = '0;
					path_d   = '0;
					state_d  = ST_DUMP_RD;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_DUMP_RD: begin
				req.re    = 1'b1;
				req.raddr = dump_k_q;
				state_d   = ST_DUMP_CAP;
			end
			ST_DUMP_CAP: begin
				path_d = path_q | (PATH_W'(top) << (NODE_W * 32'(dump_k_q)));
				if (({1'b0, dump_k_q} + depth_t'(1)) == depth_q) begin
					len_d   = depth_q;
					found_d = 1'b1;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					dump_k_d = dump_k_q + addr_t'(1);
					state_d  = ST_DUMP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/spe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_checker
// Port-level checks on the command and result channels of the enumerator.
// ----------------------------------------------------------------------------
module spe_checker
	import spe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [PATH_W-1:0]   path_nodes,
	input logic [DEPTH_W-1:0]  path_length,
	input logic                path_found
);

	// a result only appears once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted command either starts work or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command produced nothing");

	// no result without a command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && !busy) |=> !done)
		else $error("result without a command");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !path_found) |-> (path_length == '0 && path_nodes == '0))
		else $error("not-found result carries data");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && path_found) |-> (path_length != '0 && path_length <= DEPTH_W'(SLOTS)))
		else $error("found path has bad length");

endmodule

bind simple_path_enumerator spe_checker u_spe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.path_nodes  (path_nodes),
	.path_length (path_length),
	.path_found  (path_found)
);

// ----- tb/path_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_checker
// Watches the command, result and adjacency-write channels of the simple
// path enumerator. It keeps its own depth-first model of the graph search,
// queues the path expected for each accepted command and compares each
// result against the oldest one, field by field.
// ----------------------------------------------------------------------------
module path_checker
	import spe_pkg::*;
#(
	parameter int NODES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               command,
	input  node_t              source_node,
	input  node_t              target_node_in,
	input  logic               done,
	input  logic [PATH_W-1:0]  path_nodes,
	input  depth_t             path_length,
	input  logic               path_found,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  addr_t              cfg_index,
	input  mask_t              cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 paths_seen,
	output int                 misses_seen
);

	typedef struct packed {
		logic [PATH_W-1:0] nodes;
		depth_t            len;
		logic              found;
	} path_result_t;

	path_result_t      expected_paths[$];

	// search model
	mask_t             rows[SLOTS];
	node_t             stk_node[SLOTS];
	logic [NBR_W-1:0]  stk_nbr[SLOTS];
	depth_t            depth;
	mask_t             on_path;
	node_t             goal;
	logic              active;

	task automatic push_node(input node_t n);
		stk_node[depth[ADDR_W-1:0]] = n;
		// never extend a path past the goal
		stk_nbr[depth[ADDR_W-1:0]]  = (n == goal) ? NBR_W'(NODES) : '0;
		on_path[n] = 1'b1;
		depth      = depth + 1'b1;
	endtask

	task automatic find_next(output logic hit);
		addr_t            lvl;
		node_t            top_node;
		logic [NBR_W-1:0] nbr;
		hit = 1'b0;
		while (!hit && depth != '0) begin
			lvl      = addr_t'(depth - 1'b1);
			top_node = stk_node[lvl];
			nbr      = stk_nbr[lvl];
			if (nbr >= NODES) begin
				// pop a finished level
				on_path[top_node] = 1'b0;
				depth = depth - 1'b1;
			end else begin
				stk_nbr[lvl] = nbr + 1'b1;
				if (rows[top_node][nbr[ADDR_W-1:0]] && !on_path[nbr[ADDR_W-1:0]]) begin
					push_node(node_t'(nbr));
					hit = (node_t'(nbr) == goal);
				end
			end
		end
		if (!hit)
			active = 1'b0;
	endtask

	task automatic predict_path(input logic cmd, input node_t src, input node_t dst);
		logic         hit;
		path_result_t res;
		hit = 1'b0;
		if (cmd == CMD_START) begin
			depth   = '0;
			on_path = '0;
			goal    = dst;
			if (src >= NODES || dst >= NODES) begin
				active = 1'b0;
			end else begin
				active = 1'b1;
				push_node(src);
				if (src == dst)
					hit = 1'b1;
				else
					find_next(hit);
			end
		end else if (active) begin
			find_next(hit);
		end
		res = '0;
		if (hit) begin
			res.found = 1'b1;
			res.len   = depth;
			for (int k = 0; k < SLOTS; k++)
				if (k < depth)
					res.nodes[NODE_W*k +: NODE_W] = stk_node[k];
		end
		expected_paths.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		path_result_t head;
		if (!arst_n) begin
			for (int r = 0; r < SLOTS; r++)
				rows[r] = '0;
			depth       = '0;
			on_path     = '0;
			goal        = '0;
			active      = 1'b0;
			errors      = 0;
			paths_seen  = 0;
			misses_seen = 0;
			expected_paths.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				rows[cfg_index] = cfg_data;
			if (done) begin
				if (expected_paths.size() == 0) begin
					$error("unexpected result: path_nodes=%h path_length=%0d path_found=%0d",
						path_nodes, path_length, path_found);
					errors++;
				end else begin
					head = expected_paths.pop_front();
					if (path_nodes !== head.nodes) begin
						$error("path_nodes: expected %h, actual %h", head.nodes, path_nodes);
						errors++;
					end
					if (path_length !== head.len) begin
						$error("path_length: expected %0d, actual %0d", head.len, path_length);
						errors++;
					end
					if (path_found !== head.found) begin
						$error("path_found: expected %0d, actual %0d", head.found, path_found);
						errors++;
					end
					if (head.found)
						paths_seen++;
					else
						misses_seen++;
				end
			end
			if (start && !busy)
				predict_path(command, source_node, target_node_in);
		end
		pending = expected_paths.size();
	end

endmodule

// ----- tb/simple_path_enumerator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_path_enumerator_tb
// Drives start and next commands into the simple path enumerator over a
// series of directed and random graphs, with random gaps between commands,
// and leaves prediction and comparison to the path checker beside the block.
// ----------------------------------------------------------------------------
module simple_path_enumerator_tb;
	import spe_pkg::*;

	localparam int NODES        = 8;
	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int STALL_LIMIT  = 200000;
	localparam int TARGET_ITEMS = 2000;
	localparam int MAX_GAP      = 7;
	localparam int TAIL_CYCLES  = 16;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic               command        = CMD_START;
	node_t              source_node    = '0;
	node_t              target_node_in = '0;
	logic               cfg_valid      = 1'b0;
	addr_t              cfg_index      = '0;
	mask_t              cfg_data       = '0;
	logic               busy;
	logic               done;
	logic [PATH_W-1:0]  path_nodes;
	depth_t             path_length;
	logic               path_found;
	logic               cfg_ready;

	int                 fail_count;
	int                 pending_paths;
	int                 paths_seen;
	int                 misses_seen;
	int                 commands_sent  = 0;
	int                 starts_sent    = 0;
	int                 graphs_loaded  = 0;
	int                 idle_cycles    = 0;
	logic               no_gaps        = 1'b0;
	mask_t              graph[SLOTS];

	always #CLK_HALF clk = ~clk;

	simple_path_enumerator #(
		.NODES(NODES)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.source_node    (source_node),
		.target_node_in (target_node_in),
		.done           (done),
		.path_nodes     (path_nodes),
		.path_length    (path_length),
		.path_found     (path_found),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	path_checker #(
		.NODES(NODES)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.source_node    (source_node),
		.target_node_in (target_node_in),
		.done           (done),
		.path_nodes     (path_nodes),
		.path_length    (path_length),
		.path_found     (path_found),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (fail_count),
		.pending        (pending_paths),
		.paths_seen     (paths_seen),
		.misses_seen    (misses_seen)
	);

	// count cycles in which no transaction of any kind completes
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	function automatic node_t any_node();
		return node_t'($urandom_range(0, NODES - 1));
	endfunction

	task automatic issue(input logic cmd, input node_t src, input node_t dst);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start          <= 1'b1;
		command        <= cmd;
		source_node    <= src;
		target_node_in <= dst;
		do @(posedge clk); while (busy);
		commands_sent++;
		if (cmd == CMD_START)
			starts_sent++;
	endtask

	// hold off until every outstanding path has come back
	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		while (pending_paths != 0)
			@(negedge clk);
	endtask

	task automatic load_graph();
		for (int r = 0; r < SLOTS; r++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= addr_t'(r);
			cfg_data  <= graph[r];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		graphs_loaded++;
	endtask

	task automatic random_graph();
		int style;
		int density;
		style   = $urandom_range(0, 9);
		density = $urandom_range(1, 4);
		for (int r = 0; r < SLOTS; r++) begin
			for (int j = 0; j < SLOTS; j++) begin
				case (style)
					0:       graph[r][j] = 1'b0;
					1:       graph[r][j] = 1'b1;
					default: graph[r][j] = ($urandom_range(0, 7) < density);
				endcase
			end
		end
	endtask

	task automatic run_phase();
		int    budget;
		int    nexts;
		node_t src;
		node_t dst;
		random_graph();
		load_graph();
		no_gaps = ($urandom_range(0, 3) == 0);
		budget  = $urandom_range(40, 120);
		while (budget > 0) begin
			case ($urandom_range(0, 9))
				0: begin
					issue(CMD_NEXT, any_node(), any_node());
					budget--;
				end
				1: begin
					issue(CMD_START, any_node(), any_node());
					budget--;
				end
				default: begin
					src   = any_node();
					dst   = ($urandom_range(0, 5) == 0) ? src : any_node();
					nexts = $urandom_range(1, 16);
					issue(CMD_START, src, dst);
					repeat (nexts) issue(CMD_NEXT, any_node(), any_node());
					budget -= nexts + 1;
					if ($urandom_range(0, 7) == 0)
						quiesce();
				end
			endcase
		end
		quiesce();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty graph straight out of reset
		issue(CMD_NEXT, 3'd5, 3'd2);
		issue(CMD_START, 3'd3, 3'd3);
		issue(CMD_NEXT, 3'd0, 3'd0);
		issue(CMD_START, 3'd0, 3'd7);
		quiesce();

		// complete graph with self-loops: longest path first
		for (int r = 0; r < SLOTS; r++)
			graph[r] = '1;
		load_graph();
		issue(CMD_START, 3'd0, 3'd7);
		repeat (3) issue(CMD_NEXT, 3'd7, 3'd0);
		issue(CMD_START, 3'd7, 3'd0);
		issue(CMD_START, 3'd5, 3'd5);
		issue(CMD_NEXT, 3'd2, 3'd6);
		quiesce();

		// small graph: run to exhaustion, next after exhaustion, restart mid-search
		for (int r = 0; r < SLOTS; r++)
			graph[r] = '0;
		graph[0] = 8'b0000_0110;
		graph[1] = 8'b1000_0100;
		graph[2] = 8'b1000_0000;
		load_graph();
		issue(CMD_START, 3'd0, 3'd7);
		repeat (4) issue(CMD_NEXT, 3'd1, 3'd4);
		issue(CMD_START, 3'd0, 3'd7);
		issue(CMD_NEXT, 3'd6, 3'd3);
		issue(CMD_START, 3'd2, 3'd7);
		issue(CMD_NEXT, 3'd4, 3'd1);
		quiesce();

		// goal unreachable from a dense subgraph: longest fruitless search
		for (int r = 0; r < SLOTS - 1; r++)
			graph[r] = 8'h7F;
		graph[SLOTS-1] = 8'hFF;
		load_graph();
		issue(CMD_START, 3'd0, 3'd7);
		quiesce();

		while (commands_sent < TARGET_ITEMS)
			run_phase();

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d commands (%0d starts) over %0d adjacency loads,",
			commands_sent, starts_sent, graphs_loaded);
		$display("with %0d paths returned and %0d not-found answers.",
			paths_seen, misses_seen);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
